// File: design/sorted_key_table_binary_search_assert.svh
// Assertion macros for the sorted key table
`ifndef SORTED_KEY_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_KEY_TABLE_BINARY_SEARCH_ASSERT_SVH

// holds an implication on every clock edge outside reset
`define SKT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// holds a condition in the cycle after a trigger
`define SKT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/skt_pkg.sv
`default_nettype none
package skt_pkg;
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SORT   = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_LOAD,
        B_SRCH_RD,
        B_SRCH_WAIT,
        B_SRCH_CMP,
        B_SORT_NEXT,
        B_SORT_RDI,
        B_SORT_RDJ,
        B_SORT_WAIT,
        B_SORT_CMP,
        B_SORT_PUT,
        B_OUT
    } bstate_t;

    localparam int KEY_W = 64;
    localparam int TAG_W = 16;
    localparam int IDX_W = 10;
endpackage
`default_nettype wire

// File: design/skt_front.sv
`default_nettype none
// Two-entry command queue in front of the engine
module skt_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire  [1:0]           in_cmd,
    input  wire  [63:0]          in_key,
    input  wire  [15:0]          in_tag,
    output logic                 q_valid,
    input  wire                  q_ready,
    output skt_pkg::cmd_t        q_cmd,
    output logic [63:0]          q_key,
    output logic [15:0]          q_tag
);
    import skt_pkg::*;

    logic [81:0] q_mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_cmd    = cmd_t'(q_mem_reg[rd_ptr_reg][81:80]);
    assign q_key    = q_mem_reg[rd_ptr_reg][79:16];
    assign q_tag    = q_mem_reg[rd_ptr_reg][15:0];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= {in_cmd, in_key, in_tag};
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// File: design/skt_back.sv
`default_nettype none
// Table engine: append, stable insertion sort, binary search
module skt_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  q_valid,
    output logic                 q_ready,
    input  skt_pkg::cmd_t        q_cmd,
    input  wire  [63:0]          q_key,
    input  wire  [15:0]          q_tag,
    output logic                 r_valid,
    input  wire                  r_ready,
    output logic [1:0]           r_status,
    output logic [9:0]           r_index,
    output logic [15:0]          r_tag,
    output logic                 busy
);
    import skt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = AW + 2;

    logic [KEY_W+TAG_W-1:0] mem [TABLE_DEPTH];
    logic [KEY_W+TAG_W-1:0] rd_data_reg;

    bstate_t         state_reg, state_next;
    logic [CW-1:0]   count_reg;
    logic [63:0]     key_reg;
    logic [79:0]     hold_reg;
    logic [SW-1:0]   low_reg, low_next, high_reg, high_next;
    logic [CW-1:0]   i_reg, i_next, j_reg, j_next;
    logic [1:0]      st_reg, st_next;
    logic [9:0]      idx_reg, idx_next;
    logic [15:0]     tag_reg, tag_next;
    logic [SW-1:0]   mid;
    logic [SW:0]     lh_sum;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [79:0]     wdata;
    logic            count_inc;

    assign lh_sum = {1'b0, low_reg} + {1'b0, high_reg};
    assign mid    = lh_sum[SW:1];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rd_data_reg <= mem[raddr];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    unique case (q_cmd)
                        CMD_LOAD:   state_next = B_LOAD;
                        CMD_SORT:   state_next = B_SORT_NEXT;
                        CMD_LOOKUP: state_next = B_SRCH_RD;
                        default:    state_next = B_OUT;
                    endcase
                end
            end
            B_LOAD:      state_next = B_OUT;
            B_SRCH_RD:   state_next = ($signed(low_reg) > $signed(high_reg)) ? B_OUT
                                                                         : B_SRCH_WAIT;
            B_SRCH_WAIT: state_next = B_SRCH_CMP;
            B_SRCH_CMP:  state_next = (rd_data_reg[79:16] == key_reg) ? B_SRCH_WAIT
                                                                       : B_SRCH_RD;
            B_SORT_NEXT: state_next = (i_reg >= count_reg) ? B_OUT : B_SORT_RDI;
            B_SORT_RDI:  state_next = B_SORT_RDJ;
            B_SORT_RDJ:  state_next = (j_reg == '0) ? B_SORT_PUT : B_SORT_WAIT;
            B_SORT_WAIT: state_next = B_SORT_CMP;
            B_SORT_CMP:  state_next = (rd_data_reg[79:16] > hold_reg[79:16]) ? B_SORT_RDJ
                                                                              : B_SORT_PUT;
            B_SORT_PUT:  state_next = B_SORT_NEXT;
            B_OUT:       state_next = r_ready ? B_IDLE : B_OUT;
            default:     state_next = B_IDLE;
        endcase
        // hit: wait one more pass through SRCH_WAIT is avoided below by jumping to OUT
        if (state_reg == B_SRCH_CMP && rd_data_reg[79:16] == key_reg) begin
            state_next = B_OUT;
        end
    end

    always_comb begin
        q_ready   = (state_reg == B_IDLE);
        r_valid   = (state_reg == B_OUT);
        busy      = (state_reg != B_IDLE);
        r_status  = st_reg;
        r_index   = idx_reg;
        r_tag     = tag_reg;
        we        = 1'b0;
        waddr     = count_reg[AW-1:0];
        wdata     = {key_reg, hold_reg[15:0]};
        raddr     = mid[AW-1:0];
        count_inc = 1'b0;
        low_next  = low_reg;
        high_next = high_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        st_next   = st_reg;
        idx_next  = idx_reg;
        tag_next  = tag_reg;
        unique case (state_reg)
            B_IDLE: begin
                st_next   = ST_DONE;
                idx_next  = '0;
                tag_next  = '0;
                low_next  = '0;
                high_next = SW'(count_reg) - SW'(1);
                i_next    = CW'(1);
            end
            B_LOAD: begin
                if (count_reg == CW'(TABLE_DEPTH)) begin
                    st_next = ST_FULL;
                end else begin
                    we        = 1'b1;
                    count_inc = 1'b1;
                end
            end
            B_SRCH_RD: begin
                if ($signed(low_reg) > $signed(high_reg)) st_next = ST_NOT_FOUND;
            end
            B_SRCH_WAIT: raddr = mid[AW-1:0];
            B_SRCH_CMP: begin
                if (rd_data_reg[79:16] == key_reg) begin
                    st_next  = ST_FOUND;
                    idx_next = 10'(mid);
                    tag_next = rd_data_reg[15:0];
                end else if (rd_data_reg[79:16] < key_reg) begin
                    low_next = mid + SW'(1);
                end else begin
                    high_next = mid - SW'(1);
                end
            end
            B_SORT_NEXT: raddr = i_reg[AW-1:0];
            B_SORT_RDI:  j_next = i_reg;
            B_SORT_RDJ:  raddr = j_reg[AW-1:0] - AW'(1);
            B_SORT_WAIT: raddr = j_reg[AW-1:0] - AW'(1);
            B_SORT_CMP: begin
                if (rd_data_reg[79:16] > hold_reg[79:16]) begin
                    we     = 1'b1;
                    waddr  = j_reg[AW-1:0];
                    wdata  = rd_data_reg;
                    j_next = j_reg - CW'(1);
                end
            end
            B_SORT_PUT: begin
                we     = 1'b1;
                waddr  = j_reg[AW-1:0];
                wdata  = hold_reg;
                i_next = i_reg + CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == B_IDLE && q_valid) begin
            key_reg  <= q_key;
            hold_reg <= {q_key, q_tag};
        end else if (state_reg == B_SORT_RDI) begin
            hold_reg <= rd_data_reg;
        end
        low_reg  <= low_next;
        high_reg <= high_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        st_reg   <= st_next;
        idx_reg  <= idx_next;
        tag_reg  <= tag_next;
        if (!aresetn) begin
            state_reg <= B_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (count_inc) count_reg <= count_reg + CW'(1);
        end
    end
endmodule
`default_nettype wire

// File: design/sorted_key_table_binary_search.sv
// Load: IDLE, LOAD, OUT. Lookup: each probe passes SRCH_RD, SRCH_WAIT and SRCH_CMP;
// a hit leaves from SRCH_CMP, a miss from SRCH_RD; at most log2(TABLE_DEPTH)+1 probes,
// one table read port. Sort: stable insertion sort via SORT_RDJ, SORT_WAIT, SORT_CMP.
// One word at a time in the engine; a two-word queue keeps taking input.
// aresetn (synchronous, active low) empties the table count and the queue;
// table contents are not cleared.
`default_nettype none
module sorted_key_table_binary_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [87:0] s_tdata,   // command[1:0], key[65:2], entry_tag[81:66], zero pad
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata    // status[1:0], found_index[11:2], found_tag[27:12], zero
);
    import skt_pkg::*;

    logic          q_valid, q_ready, busy;
    cmd_t          q_cmd;
    logic [63:0]   q_key;
    logic [15:0]   q_tag;
    logic [1:0]    r_status;
    logic [9:0]    r_index;
    logic [15:0]   r_tag;

    skt_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(s_tdata[1:0]), .in_key(s_tdata[65:2]), .in_tag(s_tdata[81:66]),
        .q_valid(q_valid), .q_ready(q_ready),
        .q_cmd(q_cmd), .q_key(q_key), .q_tag(q_tag)
    );

    skt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready),
        .q_cmd(q_cmd), .q_key(q_key), .q_tag(q_tag),
        .r_valid(m_tvalid), .r_ready(m_tready),
        .r_status(r_status), .r_index(r_index), .r_tag(r_tag),
        .busy(busy)
    );

    assign m_tdata = {4'd0, r_tag, r_index, r_status};

`include "sorted_key_table_binary_search_assert.svh"
    `SKT_ASSERT_IMP(a_out_busy, aclk, aresetn, m_tvalid, busy, "result without busy engine")
    `SKT_ASSERT_IMP(a_no_take, aclk, aresetn, busy, !q_ready, "queue popped while busy")
    `SKT_ASSERT_NEXT(a_done, aclk, aresetn, m_tvalid && m_tready, !m_tvalid,
        "result repeated")
endmodule
`default_nettype wire
